FILE: hdl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lru page stack package
// shared widths, reset values and the per-cell control bundle
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned PAGE_W         = 32;
  localparam int unsigned CAP_W          = 7;
  localparam int unsigned DEPTH_W        = 6;
  localparam int unsigned MAX_FRAMES_DEF = 64;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 6'd63;
  localparam logic [CAP_W-1:0]   CAP_RESET = 7'd64;

  // control for one stack cell
  typedef struct packed {
    logic valid;  // cell holds a resident page
    logic shift;  // cell loads from its upper neighbor
  } cell_ctrl_t;

endpackage

FILE: hdl/lps_cell.sv
// ----------------------------------------------------------------------------
// lru page stack cell
// one stack entry: holds a page number, compares it against the probe and
// passes it on to the next cell toward the lru end
// ----------------------------------------------------------------------------
module lps_cell (
  input  logic                       clk_i,
  input  lps_pkg::cell_ctrl_t        ctrl_i,
  input  logic [lps_pkg::PAGE_W-1:0] data_i,
  input  logic [lps_pkg::PAGE_W-1:0] probe_i,
  output logic [lps_pkg::PAGE_W-1:0] data_o,
  output logic                       match_o
);
  import lps_pkg::*;

  logic [PAGE_W-1:0] page_q;
  logic [PAGE_W-1:0] page_d;

  assign page_d = ctrl_i.shift ? data_i : page_q;

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign data_o  = page_q;
  assign match_o = ctrl_i.valid && (page_q == probe_i);

endmodule

FILE: hdl/lps_match_enc.sv
// ----------------------------------------------------------------------------
// lru page stack match encoder
// turns the one-hot cell match vector into a hit flag and a stack index
// ----------------------------------------------------------------------------
module lps_match_enc #(
  parameter int unsigned Frames = lps_pkg::MAX_FRAMES_DEF,
  parameter int unsigned IdxW   = (Frames > 1) ? $clog2(Frames) : 1
) (
  input  logic [Frames-1:0] match_i,
  output logic              hit_o,
  output logic [IdxW-1:0]   idx_o
);
  import lps_pkg::*;

  // resident pages are unique, so at most one bit is set and an or-tree works
  always_comb begin
    idx_o = '0;
    for (int i = 0; i < Frames; i++) begin
      if (match_i[i]) begin
        idx_o = idx_o | IdxW'(i);
      end
    end
  end

  assign hit_o = |match_i;

endmodule

FILE: hdl/lru_page_stack_top.sv
// ----------------------------------------------------------------------------
// lru page stack
// recency-ordered stack of resident page numbers with stack-distance output
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, page_number_i    | input
//  out     | out_valid_o, out_ready_i, hit_o,         | output
//          | stack_depth_o                            |
//  cfg     | cfg_we_i, cfg_wdata_i (capacity)         | input
//
//  each transaction runs through ST_IDLE and ST_UPD: in ST_IDLE the page
//  is compared against every cell in parallel, in ST_UPD the cell chain
//  shifts one place toward the lru end and the result register loads.
//  a new page is accepted only after the previous one has shifted, set by the
//  compare-then-shift sequence through the cell chain.
//  reset clears occupancy and sets capacity to 64; cell contents are not
//  reset, cells above the occupancy never take part in a compare.
//  a stalled result is held in the output register; the next input is
//  still accepted and waits in the shift cycle until the register frees.
//
module lru_page_stack_top #(
  parameter int unsigned MAX_FRAMES = lps_pkg::MAX_FRAMES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lps_pkg::PAGE_W-1:0]  page_number_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [lps_pkg::DEPTH_W-1:0] stack_depth_o,
  // capacity register
  input  logic                        cfg_we_i,
  input  logic [lps_pkg::CAP_W-1:0]   cfg_wdata_i
);
  import lps_pkg::*;

  // index of one cell, occupancy counter, common compare width
  localparam int unsigned IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned OW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned XW = (OW > CAP_W) ? OW : CAP_W;
  localparam int unsigned EW = (IW > DEPTH_W) ? IW : DEPTH_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,  // waiting for a page, compare happens here
    ST_UPD  = 2'b10   // shift the chain and post the result
  } state_e;

  // capacity above the number of frames acts as the number of frames
  function automatic logic [OW-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [XW-1:0] cap_x;
    cap_x = XW'(cap);
    if (cap_x > XW'(MAX_FRAMES)) begin
      eff_cap = OW'(MAX_FRAMES);
    end else begin
      eff_cap = cap_x[OW-1:0];
    end
  endfunction

  state_e state_q, state_d;

  logic [CAP_W-1:0]  cap_q;
  logic [OW-1:0]     occ_q, occ_d;
  logic [OW-1:0]     cap_eff;
  logic [OW-1:0]     cfg_eff;

  // transaction held between compare and shift
  logic [PAGE_W-1:0] page_q;
  logic              hit_q;
  logic [IW-1:0]     top_q, top_d;  // deepest cell that loads on the shift
  logic              upd_q, upd_d;  // stack changes at all
  logic              grow_q, grow_d;

  // output register
  logic               out_valid_q;
  logic               res_hit_q;
  logic [DEPTH_W-1:0] res_depth_q;

  // cell chain
  logic [MAX_FRAMES-1:0] match;
  logic [PAGE_W-1:0]     chain [MAX_FRAMES];
  cell_ctrl_t            ctrl [MAX_FRAMES];

  logic          enc_hit;
  logic [IW-1:0] enc_idx;
  logic          in_acc;
  logic          upd_go;
  logic [EW-1:0] top_ext;
  logic [DEPTH_W-1:0] depth;

  assign cap_eff = eff_cap(cap_q);
  assign cfg_eff = eff_cap(cfg_wdata_i);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  // shift only when the result has somewhere to go
  assign upd_go     = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // cell chain: cell 0 is the mru end, each cell loads from the one above it
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [PAGE_W-1:0] cell_in;

    if (i == 0) begin : g_head
      assign cell_in = page_q;  // new mru page
    end else begin : g_body
      assign cell_in = chain[i-1];
    end

    assign ctrl[i].valid = (OW'(i) < occ_q);
    assign ctrl[i].shift = upd_go && upd_q && (IW'(i) <= top_q);

    lps_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .data_i  (cell_in),
      .probe_i (page_number_i),
      .data_o  (chain[i]),
      .match_o (match[i])
    );
  end

  lps_match_enc #(
    .Frames (MAX_FRAMES),
    .IdxW   (IW)
  ) u_enc (
    .match_i (match),
    .hit_o   (enc_hit),
    .idx_o   (enc_idx)
  );

  // ---------------------------------------------------------------------------
  // compare cycle: decide how far down the chain the shift reaches
  // ---------------------------------------------------------------------------
  always_comb begin
    grow_d = 1'b0;
    upd_d  = 1'b1;
    top_d  = enc_idx;
    if (!enc_hit) begin
      if (cap_eff == '0) begin
        // nothing is kept at zero capacity
        upd_d = 1'b0;
        top_d = '0;
      end else if (occ_q < cap_eff) begin
        // room left: occupancy grows by one
        grow_d = 1'b1;
        top_d  = occ_q[IW-1:0];
      end else begin
        // full: the lru page falls off the end
        top_d = IW'(cap_eff - OW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      page_q <= page_number_i;
      hit_q  <= enc_hit;
      top_q  <= top_d;
      upd_q  <= upd_d;
      grow_q <= grow_d;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // occupancy: a capacity write clamps it, a growing miss adds one
  always_comb begin
    occ_d = occ_q;
    if (cfg_we_i) begin
      if (occ_q > cfg_eff) begin
        occ_d = cfg_eff;
      end
    end else if (upd_go && grow_q) begin
      occ_d = occ_q + OW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CAP_RESET;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register, depth saturates at the field maximum
  // ---------------------------------------------------------------------------
  assign top_ext = EW'(top_q);
  assign depth   = (top_ext > EW'(DEPTH_MAX)) ? DEPTH_MAX : top_ext[DEPTH_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      res_hit_q   <= hit_q;
      res_depth_q <= hit_q ? depth : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = res_hit_q;
  assign stack_depth_o = res_depth_q;

`ifndef NO_ASSERTIONS
  // resident pages are unique, so a probe can hit at most one cell
  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one resident cell matches the probe");

  // occupancy never exceeds the effective capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cap_eff)
    else $error("occupancy above effective capacity");

  // a shift cycle always posts a result
  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |=> out_valid_o)
    else $error("shift cycle without a posted result");

  // a growing miss adds exactly one resident page
  a_occ_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && grow_q && !cfg_we_i) |=> (occ_q == $past(occ_q) + OW'(1)))
    else $error("occupancy did not grow on a miss with room left");

  // no new transaction is taken while the chain is being shifted
  a_no_accept_in_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input accepted during the shift cycle");
`endif

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// lru page stack testbench
// drives page references over the input channel and checks each hit flag
// and stack depth against a shadow recency stack kept in the bench
// ----------------------------------------------------------------------------
module testbench;

  import lps_pkg::*;

  localparam int unsigned FRAMES      = MAX_FRAMES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYC  = 4;

  typedef struct packed {
    logic               hit;
    logic [DEPTH_W-1:0] depth;
  } lookup_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [PAGE_W-1:0]  page_number_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic               hit_o;
  logic [DEPTH_W-1:0] stack_depth_o;
  logic               cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata_i   = '0;

  // shadow state of the block
  logic [PAGE_W-1:0]  shadow_stack [FRAMES];
  int unsigned        shadow_occupancy = 0;
  logic [CAP_W-1:0]   shadow_capacity  = CAP_RESET;

  lookup_t            pending_lookups [$];
  lookup_t            oldest_lookup;
  int unsigned        mismatch_count    = 0;
  int unsigned        cycle_count       = 0;
  int unsigned        sender_idle_pct   = 0;
  int unsigned        receiver_idle_pct = 0;

  lru_page_stack_top #(
    .MAX_FRAMES (FRAMES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .page_number_i (page_number_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .stack_depth_o (stack_depth_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // capacity above the stack size acts as the stack size
  function automatic int unsigned effective_capacity();
    return (shadow_capacity > FRAMES) ? FRAMES : shadow_capacity;
  endfunction

  function automatic void push_toward_lru(input int unsigned count);
    for (int i = count; i > 0; i--) begin
      if (i < FRAMES) shadow_stack[i] = shadow_stack[i-1];
    end
  endfunction

  // search from the mru end, then reorder the shadow stack
  function automatic lookup_t predict_reference(input logic [PAGE_W-1:0] page);
    lookup_t     res;
    int          found;
    int unsigned cap;
    cap   = effective_capacity();
    found = -1;
    for (int i = 0; i < shadow_occupancy; i++) begin
      if (found < 0 && shadow_stack[i] == page) found = i;
    end
    if (found >= 0) begin
      push_toward_lru(found);
      shadow_stack[0] = page;
      res.hit   = 1'b1;
      res.depth = (found > DEPTH_MAX) ? DEPTH_MAX : DEPTH_W'(found);
    end else begin
      if (cap > 0) begin
        if (shadow_occupancy < cap) begin
          push_toward_lru(shadow_occupancy);
          shadow_occupancy++;
        end else begin
          push_toward_lru(cap - 1);
        end
        shadow_stack[0] = page;
      end
      res.hit   = 1'b0;
      res.depth = '0;
    end
    return res;
  endfunction

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_lookups.size() == 0) begin
        $error("unexpected result transaction: hit %0b stack_depth %0d", hit_o, stack_depth_o);
        mismatch_count++;
      end else begin
        oldest_lookup = pending_lookups.pop_front();
        if (hit_o !== oldest_lookup.hit) begin
          $error("hit: expected %0b, actual %0b", oldest_lookup.hit, hit_o);
          mismatch_count++;
        end
        if (stack_depth_o !== oldest_lookup.depth) begin
          $error("stack_depth: expected %0d, actual %0d", oldest_lookup.depth, stack_depth_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_lookups.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // one page reference; valid stays high after the transaction so the next
  // call can follow back to back, any gap lowers it first
  task automatic send_page(input logic [PAGE_W-1:0] page);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    page_number_i <= page;
    pending_lookups.push_back(predict_reference(page));
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // stop sending and wait until every result is back and the chain is quiet
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    settle_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_capacity = value;
    // shrinking drops lru entries at once
    if (shadow_occupancy > effective_capacity()) shadow_occupancy = effective_capacity();
  endtask

  // all-zero and all-one pages, repeat hits, and a one-bit near miss
  task automatic test_page_extremes();
    send_page('0);
    send_page('1);
    send_page('0);
    send_page('0);
    send_page(32'hFFFF_FFFE);
    send_page('1);
  endtask

  task automatic test_capacity_zero();
    write_capacity('0);
    send_page(32'h0000_0005);
    send_page(32'h0000_0005);
    send_page('1);
  endtask

  // full stack drops the lru page on a miss
  task automatic test_lru_eviction();
    write_capacity(7'd3);
    send_page(32'hA5A5_0001);
    send_page(32'hA5A5_0002);
    send_page(32'hA5A5_0003);
    send_page(32'hA5A5_0004);
    send_page(32'hA5A5_0001);
    send_page(32'hA5A5_0003);
  endtask

  // lowering the capacity below occupancy trims the lru end right away
  task automatic test_capacity_shrink();
    write_capacity(7'd64);
    send_page(32'h1234_0000);
    send_page(32'h1234_0001);
    send_page(32'h1234_0002);
    send_page(32'h1234_0003);
    write_capacity(7'd2);
    send_page(32'h1234_0002);
    send_page(32'h1234_0001);
  endtask

  // a cyclic sweep over exactly the effective capacity hits at the deepest
  // slot, one page more misses every time
  task automatic test_full_stack_sweep();
    logic [PAGE_W-1:0] pages [$];
    write_capacity(CAP_W'($urandom_range(FRAMES, 127)));
    repeat (FRAMES + 1) pages.push_back($urandom);
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < FRAMES; i++) send_page(pages[i]);
    end
    for (int pass = 0; pass < 2; pass++) begin
      foreach (pages[i]) send_page(pages[i]);
    end
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned n_items);
    logic [PAGE_W-1:0] pool [$];
    logic [PAGE_W-1:0] page;
    logic [CAP_W-1:0]  cap;
    int unsigned       sent;
    int unsigned       eff;
    int unsigned       pool_size;
    int unsigned       mode;
    int unsigned       burst;
    sender_idle_pct   = tx_pct;
    receiver_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       cap = '0;
        1:       cap = 7'd1;
        2:       cap = 7'd64;
        3:       cap = CAP_W'($urandom_range(65, 127));
        default: cap = CAP_W'($urandom_range(2, 63));
      endcase
      write_capacity(cap);
      eff  = effective_capacity();
      mode = $urandom_range(2);
      if (mode == 0) pool_size = (eff == 0) ? 1 : eff + $urandom_range(0, 1);
      else           pool_size = $urandom_range(1, 72);
      pool.delete();
      for (int i = 0; i < pool_size; i++) begin
        // neighbors a single bit apart stress the compare
        if (i > 0 && $urandom_range(3) == 0) pool.push_back(pool[i-1] ^ (32'h1 << $urandom_range(31)));
        else                                 pool.push_back($urandom);
      end
      burst = (mode == 0) ? 2 * pool_size + $urandom_range(0, 20) : $urandom_range(40, 90);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(19) == 0)  page = $urandom;
        else if (mode == 0)           page = pool[k % pool_size];
        else if (mode == 1)           page = pool[$urandom_range(0, pool_size - 1)];
        else                          page = pool[$urandom_range(0, $urandom_range(0, pool_size - 1))];
        send_page(page);
      end
      sent += burst;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_pct   = 36;
    receiver_idle_pct = 60;
    test_page_extremes();
    test_capacity_zero();
    test_lru_eviction();
    test_capacity_shrink();
    test_full_stack_sweep();
    test_random_traffic(36, 60, 550);
    test_random_traffic(60, 36, 550);
    test_random_traffic(0, 0, 550);
    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lps_pkg.sv
hdl/lps_cell.sv
hdl/lps_match_enc.sv
hdl/lru_page_stack_top.sv
test/testbench.sv
